FILE: rtl/core/haversine_distance_assert.svh
// assertion macros for the haversine distance checker
// expects clk and rst_n in the scope where a macro is used
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH

// same-cycle implication
`define HVD_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define HVD_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/hvd_pkg.sv
// shared types, constants and the arctangent table for the haversine distance block
// no dependencies
package hvd_pkg;

    localparam int ANG_W        = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int STAGE_STEPS  = 2;
    localparam int ROT_STAGES   = (CORDIC_STEPS + STAGE_STEPS - 1) / STAGE_STEPS;
    localparam int SQRT_BITS    = 31;
    localparam int SQRT_STAGES  = (SQRT_BITS + STAGE_STEPS - 1) / STAGE_STEPS;

    localparam logic signed [ANG_W-1:0] ONE_ANG  = ANG_W'(1073741824);
    localparam logic signed [ANG_W-1:0] GAIN_INV = ANG_W'(32'h26DD3B6A);

    localparam logic [63:0] RAD_MUL64 =
        (64'h6487ED5110B4611A + 64'd900000000) / 64'd1800000000;
    localparam logic [31:0] RAD_MUL = RAD_MUL64[31:0];

    typedef struct packed {
        logic signed [ANG_W-1:0] dlat;
        logic signed [ANG_W-1:0] dlon;
        logic signed [ANG_W-1:0] lat_a;
        logic signed [ANG_W-1:0] lat_b;
    } hvd_ang_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:       r = ANG_W'(843314857);
            1:       r = ANG_W'(497837829);
            2:       r = ANG_W'(263043837);
            3:       r = ANG_W'(133525159);
            4:       r = ANG_W'(67021687);
            5:       r = ANG_W'(33543516);
            6:       r = ANG_W'(16775851);
            7:       r = ANG_W'(8388437);
            8:       r = ANG_W'(4194283);
            9:       r = ANG_W'(2097149);
            10:      r = ANG_W'(1048576);
            11:      r = ANG_W'(524288);
            12:      r = ANG_W'(262144);
            13:      r = ANG_W'(131072);
            14:      r = ANG_W'(65536);
            15:      r = ANG_W'(32768);
            16:      r = ANG_W'(16384);
            17:      r = ANG_W'(8192);
            18:      r = ANG_W'(4096);
            19:      r = ANG_W'(2048);
            20:      r = ANG_W'(1024);
            21:      r = ANG_W'(512);
            22:      r = ANG_W'(256);
            23:      r = ANG_W'(128);
            24:      r = ANG_W'(64);
            25:      r = ANG_W'(32);
            26:      r = ANG_W'(16);
            27:      r = ANG_W'(8);
            28:      r = ANG_W'(4);
            29:      r = ANG_W'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/haversine_distance.sv
// haversine great-circle distance, top level with input skid, haversine term and scaling
// uses hvd_pkg, hvd_front, hvd_rot, hvd_sqrt, hvd_vec
//
// Input channel (in_valid / in_ready) takes one word of two positions, latitude and
// longitude in 1e-7 degree. Output channel (out_valid / out_ready) returns one word,
// distance_m, the great-circle distance in meters, rounded and saturated at
// 20015087 m. Words come out in the order they went in.
// The pipeline is 63 register stages deep: 6 input stages, 15 sine/cosine cordic
// stages, 7 haversine stages, 16 square root stages, 15 arctangent cordic stages and
// 4 scaling stages; each cordic stage does two iterations, as does each root stage
// but the last, which does one. Throughput is one word per cycle while not stalled.
// When the receiver holds out_ready low with out_valid high, the whole pipeline
// freezes; one more input word is taken into a skid register, then in_ready drops
// until the output moves again. Bubbles in the pipeline are not squeezed out.
// Reset clears all valid bits and the skid valid flag; in_ready is high right after.
module haversine_distance (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [30:0] lat_a,
    input  logic signed [31:0] lon_a,
    input  logic signed [30:0] lat_b,
    input  logic signed [31:0] lon_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [24:0]        distance_m
);
    localparam int W      = hvd_pkg::ANG_W;
    localparam int MIX_D  = 7;
    localparam int OUT_D  = 4;

    localparam logic [30:0] ONE_U     = 31'd1073741824;
    localparam logic [61:0] HALF_LSB  = 62'd536870912;
    localparam logic [26:0] DIAM_DM   = 27'd127420176;
    localparam logic [58:0] DIST_HALF = 59'd5368709120;
    localparam logic [31:0] RECIP10   = 32'hCCCCCCCD;
    localparam logic [24:0] DIST_MAX  = 25'd20015087;

    function automatic logic [30:0] mag_clamp(input logic signed [W-1:0] v);
        logic [30:0]         r;
        logic signed [W-1:0] n;
        n = -v;
        if (v > hvd_pkg::ONE_ANG || v < -hvd_pkg::ONE_ANG)
        begin
            r = ONE_U;
        end
        else if (v[W-1])
        begin
            r = n[30:0];
        end
        else
        begin
            r = v[30:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] pos_clamp(input logic signed [W-1:0] v);
        logic [30:0] r;
        if (v[W-1])
        begin
            r = '0;
        end
        else if (v > hvd_pkg::ONE_ANG)
        begin
            r = ONE_U;
        end
        else
        begin
            r = v[30:0];
        end
        return r;
    endfunction

    logic               en;
    logic               skid_valid_reg, skid_valid_next;
    logic signed [30:0] skid_lat_a_reg, skid_lat_b_reg;
    logic signed [31:0] skid_lon_a_reg, skid_lon_b_reg;
    logic signed [30:0] f_lat_a, f_lat_b;
    logic signed [31:0] f_lon_a, f_lon_b;

    logic               fr_vld;
    hvd_pkg::hvd_ang_t  fr_ang;
    logic               rot_vld;
    logic signed [W-1:0] sin_dlat, sin_dlon, cos_lat_a, cos_lat_b;

    logic [MIX_D-1:0]   mvld_reg;
    logic [30:0]        sl_reg, sn_reg, ca_reg, cb_reg;
    logic [61:0]        plat_reg, plon_reg, pcc_reg;
    logic [61:0]        rlat, rlon, rcc, ra;
    logic [30:0]        hs_lat_reg, hs_lon_reg, cc_reg;
    logic [61:0]        pa_reg;
    logic [30:0]        hs4_reg, hs5_reg, t_reg;
    logic [31:0]        a_sum;
    logic [30:0]        a_reg, a7_reg, om_reg;

    logic               sq_vld;
    logic [30:0]        sq_x, sq_y;
    logic               vec_vld;
    logic [30:0]        z_ang;

    logic [OUT_D-1:0]   dvld_reg;
    logic [57:0]        pz_reg;
    logic [58:0]        q_sum;
    logic [27:0]        q_reg;
    logic [59:0]        m_reg;
    logic [24:0]        dist_reg, dist_next;

    assign en       = !dvld_reg[OUT_D-1] || out_ready;
    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        if (skid_valid_reg)
        begin
            skid_valid_next = !en;
        end
        else
        begin
            skid_valid_next = in_valid && !en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_lat_a_reg <= lat_a;
            skid_lon_a_reg <= lon_a;
            skid_lat_b_reg <= lat_b;
            skid_lon_b_reg <= lon_b;
        end
    end

    assign f_lat_a = skid_valid_reg ? skid_lat_a_reg : lat_a;
    assign f_lon_a = skid_valid_reg ? skid_lon_a_reg : lon_a;
    assign f_lat_b = skid_valid_reg ? skid_lat_b_reg : lat_b;
    assign f_lon_b = skid_valid_reg ? skid_lon_b_reg : lon_b;

    hvd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (skid_valid_reg || in_valid),
        .lat_a   (f_lat_a),
        .lon_a   (f_lon_a),
        .lat_b   (f_lat_b),
        .lon_b   (f_lon_b),
        .vld_out (fr_vld),
        .ang     (fr_ang)
    );

    hvd_rot u_rot_dlat (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (fr_vld),
        .theta   (fr_ang.dlat),
        .vld_out (rot_vld),
        .sin_q   (sin_dlat),
        .cos_q   ()
    );

    hvd_rot u_rot_dlon (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (fr_vld),
        .theta   (fr_ang.dlon),
        .vld_out (),
        .sin_q   (sin_dlon),
        .cos_q   ()
    );

    hvd_rot u_rot_lat_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (fr_vld),
        .theta   (fr_ang.lat_a),
        .vld_out (),
        .sin_q   (),
        .cos_q   (cos_lat_a)
    );

    hvd_rot u_rot_lat_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (fr_vld),
        .theta   (fr_ang.lat_b),
        .vld_out (),
        .sin_q   (),
        .cos_q   (cos_lat_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvld_reg <= '0;
            dvld_reg <= '0;
        end
        else if (en)
        begin
            mvld_reg <= {mvld_reg[MIX_D-2:0], rot_vld};
            dvld_reg <= {dvld_reg[OUT_D-2:0], vec_vld};
        end
    end

    assign rlat  = plat_reg + HALF_LSB;
    assign rlon  = plon_reg + HALF_LSB;
    assign rcc   = pcc_reg + HALF_LSB;
    assign ra    = pa_reg + HALF_LSB;
    assign a_sum = {1'b0, hs5_reg} + {1'b0, t_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_reg     <= mag_clamp(sin_dlat);
            sn_reg     <= mag_clamp(sin_dlon);
            ca_reg     <= pos_clamp(cos_lat_a);
            cb_reg     <= pos_clamp(cos_lat_b);
            plat_reg   <= 62'(sl_reg) * 62'(sl_reg);
            plon_reg   <= 62'(sn_reg) * 62'(sn_reg);
            pcc_reg    <= 62'(ca_reg) * 62'(cb_reg);
            hs_lat_reg <= rlat[60:30];
            hs_lon_reg <= rlon[60:30];
            cc_reg     <= rcc[60:30];
            pa_reg     <= 62'(cc_reg) * 62'(hs_lon_reg);
            hs4_reg    <= hs_lat_reg;
            t_reg      <= ra[60:30];
            hs5_reg    <= hs4_reg;
            a_reg      <= (a_sum > {1'b0, ONE_U}) ? ONE_U : a_sum[30:0];
            om_reg     <= ONE_U - a_reg;
            a7_reg     <= a_reg;
        end
    end

    hvd_sqrt u_sqrt_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (mvld_reg[MIX_D-1]),
        .val     (om_reg),
        .vld_out (sq_vld),
        .root    (sq_x)
    );

    hvd_sqrt u_sqrt_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (mvld_reg[MIX_D-1]),
        .val     (a7_reg),
        .vld_out (),
        .root    (sq_y)
    );

    hvd_vec u_vec (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (sq_vld),
        .x_in    (sq_x),
        .y_in    (sq_y),
        .vld_out (vec_vld),
        .angle   (z_ang)
    );

    assign q_sum     = {1'b0, pz_reg} + DIST_HALF;
    assign dist_next = (m_reg[59:35] > DIST_MAX) ? DIST_MAX : m_reg[59:35];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pz_reg   <= 58'(z_ang) * 58'(DIAM_DM);
            q_reg    <= q_sum[57:30];
            m_reg    <= 60'(q_reg) * 60'(RECIP10);
            dist_reg <= dist_next;
        end
    end

    assign out_valid  = dvld_reg[OUT_D-1];
    assign distance_m = dist_reg;

endmodule

FILE: rtl/core/hvd_front.sv
// input conditioning: latitude clamp, differences, longitude wrap, degree to radian
// uses hvd_pkg
module hvd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  logic signed [30:0]    lat_a,
    input  logic signed [31:0]    lon_a,
    input  logic signed [30:0]    lat_b,
    input  logic signed [31:0]    lon_b,
    output logic                  vld_out,
    output hvd_pkg::hvd_ang_t     ang
);
    localparam int W         = hvd_pkg::ANG_W;
    localparam int LANES     = 4;
    localparam int LANE_DLAT = 0;
    localparam int LANE_DLON = 1;
    localparam int LANE_LATA = 2;
    localparam int LANE_LATB = 3;
    localparam int DEPTH     = 6;

    localparam logic signed [30:0] LAT_MAX   = 31'sd900000000;
    localparam logic signed [30:0] LAT_MIN   = -31'sd900000000;
    localparam logic signed [32:0] HALF_TURN = 33'sd1800000000;
    localparam logic signed [32:0] TURN      = 33'sd3600000000;

    logic [DEPTH-1:0] vld_reg;

    logic signed [30:0] lat1_reg, lat2_reg, lat1_next, lat2_next;
    logic signed [31:0] dlat_reg, dlat_next;
    logic signed [32:0] dlon_reg, dlon_next;

    logic signed [31:0] ang_reg [LANES];
    logic signed [31:0] ang_next [LANES];
    logic signed [32:0] wrap;
    logic [30:0]        mag_reg [LANES];
    logic [30:0]        mag_next [LANES];
    logic [LANES-1:0]   neg3_reg, neg4_reg, neg5_reg;
    logic [62:0]        prod_reg [LANES];
    logic [30:0]        rad_reg [LANES];
    logic [30:0]        rad_next [LANES];
    logic signed [W-1:0] theta_reg [LANES];
    logic signed [W-1:0] theta_next [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], vld_in};
        end
    end

    always_comb
    begin
        if (lat_a > LAT_MAX)
        begin
            lat1_next = LAT_MAX;
        end
        else if (lat_a < LAT_MIN)
        begin
            lat1_next = LAT_MIN;
        end
        else
        begin
            lat1_next = lat_a;
        end
        if (lat_b > LAT_MAX)
        begin
            lat2_next = LAT_MAX;
        end
        else if (lat_b < LAT_MIN)
        begin
            lat2_next = LAT_MIN;
        end
        else
        begin
            lat2_next = lat_b;
        end
        dlat_next = {lat2_next[30], lat2_next} - {lat1_next[30], lat1_next};
        dlon_next = {lon_b[31], lon_b} - {lon_a[31], lon_a};
    end

    always_comb
    begin
        if (dlon_reg > HALF_TURN)
        begin
            wrap = dlon_reg - TURN;
        end
        else if (dlon_reg < -HALF_TURN)
        begin
            wrap = dlon_reg + TURN;
        end
        else
        begin
            wrap = dlon_reg;
        end
        ang_next[LANE_DLAT] = dlat_reg;
        ang_next[LANE_DLON] = wrap[31:0];
        ang_next[LANE_LATA] = {lat1_reg[30], lat1_reg};
        ang_next[LANE_LATB] = {lat2_reg[30], lat2_reg};
    end

    always_comb
    begin
        logic signed [31:0] n;
        for (int k = 0; k < LANES; k++)
        begin
            n = -ang_reg[k];
            mag_next[k] = ang_reg[k][31] ? n[30:0] : ang_reg[k][30:0];
        end
    end

    always_comb
    begin
        logic [63:0] sum;
        int          sh;
        for (int k = 0; k < LANES; k++)
        begin
            sh  = (k == LANE_DLAT || k == LANE_DLON) ? 32 : 31;
            sum = {1'b0, prod_reg[k]} + (64'd1 << (sh - 1));
            rad_next[k] = 31'(sum >> sh);
        end
    end

    always_comb
    begin
        logic signed [W-1:0] ext;
        for (int k = 0; k < LANES; k++)
        begin
            ext = {{(W-31){1'b0}}, rad_reg[k]};
            theta_next[k] = neg5_reg[k] ? -ext : ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= lat1_next;
            lat2_reg <= lat2_next;
            dlat_reg <= dlat_next;
            dlon_reg <= dlon_next;
            for (int k = 0; k < LANES; k++)
            begin
                ang_reg[k]   <= ang_next[k];
                mag_reg[k]   <= mag_next[k];
                neg3_reg[k]  <= ang_reg[k][31];
                prod_reg[k]  <= 63'(mag_reg[k]) * 63'(hvd_pkg::RAD_MUL);
                neg4_reg[k]  <= neg3_reg[k];
                rad_reg[k]   <= rad_next[k];
                neg5_reg[k]  <= neg4_reg[k];
                theta_reg[k] <= theta_next[k];
            end
        end
    end

    assign vld_out   = vld_reg[DEPTH-1];
    assign ang.dlat  = theta_reg[LANE_DLAT];
    assign ang.dlon  = theta_reg[LANE_DLON];
    assign ang.lat_a = theta_reg[LANE_LATA];
    assign ang.lat_b = theta_reg[LANE_LATB];

endmodule

FILE: rtl/core/hvd_rot.sv
// pipelined rotation-mode cordic giving sine and cosine of a q4.30 angle
// uses hvd_pkg
module hvd_rot (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               vld_in,
    input  logic signed [hvd_pkg::ANG_W-1:0]   theta,
    output logic                               vld_out,
    output logic signed [hvd_pkg::ANG_W-1:0]   sin_q,
    output logic signed [hvd_pkg::ANG_W-1:0]   cos_q
);
    localparam int W      = hvd_pkg::ANG_W;
    localparam int STAGES = hvd_pkg::ROT_STAGES;
    localparam int SPS    = hvd_pkg::STAGE_STEPS;

    logic [STAGES-1:0]   vld_reg;
    logic signed [W-1:0] x_reg [STAGES];
    logic signed [W-1:0] y_reg [STAGES];
    logic signed [W-1:0] z_reg [STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], vld_in};
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic signed [W-1:0] x_src, y_src, z_src;
        logic signed [W-1:0] x_next, y_next, z_next, x_tmp;

        if (s == 0)
        begin : g_head
            assign x_src = hvd_pkg::GAIN_INV;
            assign y_src = '0;
            assign z_src = theta;
        end
        else
        begin : g_body
            assign x_src = x_reg[s-1];
            assign y_src = y_reg[s-1];
            assign z_src = z_reg[s-1];
        end

        always_comb
        begin
            x_next = x_src;
            y_next = y_src;
            z_next = z_src;
            x_tmp  = x_src;
            for (int j = 0; j < SPS; j++)
            begin
                if (s * SPS + j < hvd_pkg::CORDIC_STEPS)
                begin
                    if (!z_next[W-1])
                    begin
                        x_tmp  = x_next - (y_next >>> (s * SPS + j));
                        y_next = y_next + (x_next >>> (s * SPS + j));
                        z_next = z_next - hvd_pkg::atan_q30(s * SPS + j);
                    end
                    else
                    begin
                        x_tmp  = x_next + (y_next >>> (s * SPS + j));
                        y_next = y_next - (x_next >>> (s * SPS + j));
                        z_next = z_next + hvd_pkg::atan_q30(s * SPS + j);
                    end
                    x_next = x_tmp;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s] <= x_next;
                y_reg[s] <= y_next;
                z_reg[s] <= z_next;
            end
        end
    end

    assign vld_out = vld_reg[STAGES-1];
    assign sin_q   = y_reg[STAGES-1];
    assign cos_q   = x_reg[STAGES-1];

endmodule

FILE: rtl/core/hvd_sqrt.sv
// pipelined digit-by-digit floor square root of a q1.30 value scaled by 2^30
// uses hvd_pkg
module hvd_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            vld_in,
    input  logic [hvd_pkg::SQRT_BITS-1:0]   val,
    output logic                            vld_out,
    output logic [hvd_pkg::SQRT_BITS-1:0]   root
);
    localparam int RB     = hvd_pkg::SQRT_BITS;
    localparam int REM_W  = 2 * RB;
    localparam int STAGES = hvd_pkg::SQRT_STAGES;
    localparam int SPS    = hvd_pkg::STAGE_STEPS;

    logic [STAGES-1:0] vld_reg;
    logic [REM_W-1:0]  rem_reg [STAGES];
    logic [RB-1:0]     root_reg [STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], vld_in};
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [REM_W-1:0] rem_src, rem_next, trial;
        logic [RB-1:0]    root_src, root_next;

        if (s == 0)
        begin : g_head
            assign rem_src  = {1'b0, val, {(RB-1){1'b0}}};
            assign root_src = '0;
        end
        else
        begin : g_body
            assign rem_src  = rem_reg[s-1];
            assign root_src = root_reg[s-1];
        end

        always_comb
        begin
            rem_next  = rem_src;
            root_next = root_src;
            trial     = '0;
            for (int j = 0; j < SPS; j++)
            begin
                if (s * SPS + j < RB)
                begin
                    trial = (REM_W'(root_next) << (RB - s * SPS - j))
                          | (REM_W'(1) << (2 * (RB - 1 - s * SPS - j)));
                    if (rem_next >= trial)
                    begin
                        rem_next  = rem_next - trial;
                        root_next = root_next | (RB'(1) << (RB - 1 - s * SPS - j));
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign vld_out = vld_reg[STAGES-1];
    assign root    = root_reg[STAGES-1];

endmodule

FILE: rtl/core/hvd_vec.sv
// pipelined vectoring-mode cordic giving the angle of (x, y), clamped at zero
// uses hvd_pkg
module hvd_vec (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            vld_in,
    input  logic [hvd_pkg::SQRT_BITS-1:0]   x_in,
    input  logic [hvd_pkg::SQRT_BITS-1:0]   y_in,
    output logic                            vld_out,
    output logic [30:0]                     angle
);
    localparam int W      = hvd_pkg::ANG_W;
    localparam int STAGES = hvd_pkg::ROT_STAGES;
    localparam int SPS    = hvd_pkg::STAGE_STEPS;

    logic [STAGES-1:0]   vld_reg;
    logic signed [W-1:0] x_reg [STAGES];
    logic signed [W-1:0] y_reg [STAGES];
    logic signed [W-1:0] z_reg [STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], vld_in};
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic signed [W-1:0] x_src, y_src, z_src;
        logic signed [W-1:0] x_next, y_next, z_next, x_tmp;

        if (s == 0)
        begin : g_head
            assign x_src = {{(W-hvd_pkg::SQRT_BITS){1'b0}}, x_in};
            assign y_src = {{(W-hvd_pkg::SQRT_BITS){1'b0}}, y_in};
            assign z_src = '0;
        end
        else
        begin : g_body
            assign x_src = x_reg[s-1];
            assign y_src = y_reg[s-1];
            assign z_src = z_reg[s-1];
        end

        always_comb
        begin
            x_next = x_src;
            y_next = y_src;
            z_next = z_src;
            x_tmp  = x_src;
            for (int j = 0; j < SPS; j++)
            begin
                if (s * SPS + j < hvd_pkg::CORDIC_STEPS)
                begin
                    if (!y_next[W-1])
                    begin
                        x_tmp  = x_next + (y_next >>> (s * SPS + j));
                        y_next = y_next - (x_next >>> (s * SPS + j));
                        z_next = z_next + hvd_pkg::atan_q30(s * SPS + j);
                    end
                    else
                    begin
                        x_tmp  = x_next - (y_next >>> (s * SPS + j));
                        y_next = y_next + (x_next >>> (s * SPS + j));
                        z_next = z_next - hvd_pkg::atan_q30(s * SPS + j);
                    end
                    x_next = x_tmp;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s] <= x_next;
                y_reg[s] <= y_next;
                z_reg[s] <= z_next;
            end
        end
    end

    assign vld_out = vld_reg[STAGES-1];
    assign angle   = z_reg[STAGES-1][W-1] ? '0 : z_reg[STAGES-1][30:0];

endmodule

FILE: rtl/core/hvd_checker.sv
// port-level assertions for the haversine distance block, bound to the top level
// uses haversine_distance_assert.svh
`include "haversine_distance_assert.svh"

module hvd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [30:0] lat_a,
    input  logic signed [31:0] lon_a,
    input  logic signed [30:0] lat_b,
    input  logic signed [31:0] lon_b,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [24:0]        distance_m
);

    `HVD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance_m), "stalled word changed")
    `HVD_ASSERT_NOW(a_dist_max, out_valid, distance_m <= 25'd20015087, "distance above half circumference")
    `HVD_ASSERT_NOW(a_ready_fall, $fell(in_ready), $past(in_valid), "in_ready fell with no word offered")
    `HVD_ASSERT_NOW(a_ready_low, !in_ready, $past(out_valid && !out_ready), "in_ready low without output stall")

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);
